@@ src/stream_key_substitution_macros.svh @@
// Assertion macros for the key substitution RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef STREAM_KEY_SUBSTITUTION_MACROS_SVH
`define STREAM_KEY_SUBSTITUTION_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SKS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sks_pkg.sv @@
// Shared types and constants for the key substitution block.
// No dependencies; the interfaces, sks_out_reg, sks_core and the top level import this package.
package sks_pkg;

    localparam int MAX_KEYS_DEF      = 4;
    localparam int PATTERN_BYTES_DEF = 16;
    localparam int VALUE_BYTES_DEF   = 64;
    localparam int ACTIVE_W          = 3;

    localparam logic [7:0] OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] CLOSE_BRACE = 8'h7D;

    typedef logic [1:0]          action_t;
    typedef logic [7:0]          byte_t;
    typedef logic [1:0]          entry_t;
    typedef logic [5:0]          char_idx_t;
    typedef logic [ACTIVE_W-1:0] active_t;

    localparam action_t ACT_STREAM   = 2'd0;
    localparam action_t ACT_END      = 2'd1;
    localparam action_t ACT_LOAD_PAT = 2'd2;
    localparam action_t ACT_LOAD_VAL = 2'd3;

    // One output byte handed from the sequencer to the output register
    typedef struct packed {
        logic  push;
        byte_t data;
        logic  last;
    } emit_t;

endpackage

@@ src/sks_if.sv @@
// Valid/ready channel interfaces for input items and result bytes.
// Depends on sks_pkg for the field types.
interface sks_in_if;
    import sks_pkg::*;

    logic      valid;
    logic      ready;
    action_t   action;
    byte_t     data_byte;
    entry_t    entry_index;
    char_idx_t char_index;
    logic      final_char;

    modport source (
        output valid, action, data_byte, entry_index, char_index, final_char,
        input  ready
    );
    modport sink (
        input  valid, action, data_byte, entry_index, char_index, final_char,
        output ready
    );
endinterface

interface sks_out_if;
    import sks_pkg::*;

    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  run_end;

    modport source (output valid, out_byte, run_end, input ready);
    modport sink (input valid, out_byte, run_end, output ready);
endinterface

@@ src/sks_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module sks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/sks_out_reg.sv @@
// Output register stage: holds one result byte until the sink takes it.
// Depends on sks_pkg and sks_if.
module sks_out_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  sks_pkg::emit_t  emit,
    output logic            slot_free,
    sks_out_if.source       result
);
    import sks_pkg::*;

    logic  valid_reg, valid_next;
    byte_t data_reg, data_next;
    logic  last_reg, last_next;

    assign slot_free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (emit.push)
        begin
            valid_next = 1'b1;
            data_next  = emit.data;
            last_next  = emit.last;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign result.valid    = valid_reg;
    assign result.out_byte = data_reg;
    assign result.run_end  = last_reg;

endmodule

@@ src/sks_core.sv @@
// Match sequencer: candidate tracking, table loads and byte emission.
// Depends on sks_pkg, sks_if and the macro header; drives both RAMs.
`include "stream_key_substitution_macros.svh"

module sks_core #(
    parameter int MAX_KEYS      = sks_pkg::MAX_KEYS_DEF,
    parameter int PATTERN_BYTES = sks_pkg::PATTERN_BYTES_DEF,
    parameter int VALUE_BYTES   = sks_pkg::VALUE_BYTES_DEF,
    localparam int KW     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
    localparam int PAW    = $clog2(PATTERN_BYTES),
    localparam int VDEPTH = MAX_KEYS * VALUE_BYTES,
    localparam int VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  sks_pkg::active_t        cfg_wdata,
    sks_in_if.sink                  item,
    input  logic                    slot_free,
    output sks_pkg::emit_t          emit,
    output logic                    pat_re,
    output logic [PAW-1:0]          pat_raddr,
    output logic                    pat_we,
    output logic [PAW-1:0]          pat_waddr,
    output logic [8*MAX_KEYS-1:0]   pat_wdata,
    input  logic [8*MAX_KEYS-1:0]   pat_rdata,
    output logic                    val_re,
    output logic [VAW-1:0]          val_raddr,
    output logic                    val_we,
    output logic [VAW-1:0]          val_waddr,
    output logic [7:0]              val_wdata,
    input  logic [7:0]              val_rdata
);
    import sks_pkg::*;

    localparam int MW  = $clog2(PATTERN_BYTES + 4);
    localparam int PLW = $clog2(PATTERN_BYTES + 1);
    localparam int VLW = $clog2(VALUE_BYTES + 1);
    localparam int STW = 3;

    localparam logic [STW-1:0] ST_IDLE  = 3'd0;
    localparam logic [STW-1:0] ST_MATCH = 3'd1;
    localparam logic [STW-1:0] ST_PLOAD = 3'd2;
    localparam logic [STW-1:0] ST_PASS  = 3'd3;
    localparam logic [STW-1:0] ST_BRACE = 3'd4;
    localparam logic [STW-1:0] ST_PWR   = 3'd5;
    localparam logic [STW-1:0] ST_VWR   = 3'd6;

    logic [STW-1:0]      state_reg, state_next;
    active_t             active_reg, active_next;
    logic [MW-1:0]       matched_reg, matched_next;
    logic [MAX_KEYS-1:0] mask_reg, mask_next;
    logic [PLW-1:0]      pat_len_reg [MAX_KEYS];
    logic [PLW-1:0]      pat_len_next [MAX_KEYS];
    logic [VLW-1:0]      val_len_reg [MAX_KEYS];
    logic [VLW-1:0]      val_len_next [MAX_KEYS];

    byte_t               byte_reg, byte_next;
    logic [KW-1:0]       entry_reg, entry_next;
    logic [PAW-1:0]      pos_reg, pos_next;
    logic                last_reg, last_next;
    logic [KW-1:0]       key_reg, key_next;
    logic [MW-1:0]       cnt_reg, cnt_next;
    logic [MW-1:0]       plen_reg, plen_next;
    logic                tail_reg, tail_next;
    logic [VLW-1:0]      vcnt_reg, vcnt_next;
    logic [VLW-1:0]      vlen_reg, vlen_next;
    logic [1:0]          brace_reg, brace_next;

    logic                accept;
    logic                load_ok;
    logic [MAX_KEYS-1:0] all_mask;
    logic [MAX_KEYS-1:0] eq;
    logic [MAX_KEYS-1:0] done;
    byte_t               wb [MAX_KEYS];
    logic                full_any;
    logic [KW-1:0]       full_key;
    logic [KW-1:0]       first_key;
    logic [MW-1:0]       cnt_inc;
    logic [VLW-1:0]      vcnt_inc;
    byte_t               walk_byte;

    // RAM row holding pattern position p; braces need no row
    function automatic logic [PAW-1:0] row_of(input logic [MW-1:0] p);
        logic [PAW-1:0] r;
        r = '0;
        if (32'(p) >= 2 && 32'(p) - 2 < PATTERN_BYTES)
        begin
            r = PAW'(32'(p) - 2);
        end
        return r;
    endfunction

    // Byte p of "{{" key "}}"
    function automatic byte_t wrapped_byte(input logic [MW-1:0] p,
                                           input logic [PLW-1:0] len,
                                           input byte_t lane);
        byte_t w;
        if (32'(p) < 2)
        begin
            w = OPEN_BRACE;
        end
        else if (32'(p) < 32'(len) + 2)
        begin
            w = lane;
        end
        else
        begin
            w = CLOSE_BRACE;
        end
        return w;
    endfunction

    function automatic logic [VAW-1:0] val_addr(input logic [KW-1:0] k,
                                                input logic [VLW-1:0] i);
        return VAW'(32'(k) * VALUE_BYTES + 32'(i));
    endfunction

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign load_ok    = (matched_reg == '0) && (32'(item.entry_index) < MAX_KEYS);
    assign cnt_inc    = cnt_reg + MW'(1);
    assign vcnt_inc   = vcnt_reg + VLW'(1);
    assign walk_byte  = wrapped_byte(cnt_reg, pat_len_reg[key_reg],
                                     pat_rdata[{key_reg, 3'b000} +: 8]);

    // Per-key compare against the row read for the current position
    always_comb
    begin
        for (int k = 0; k < MAX_KEYS; k++)
        begin
            all_mask[k] = 32'(k) < 32'(active_reg);
            wb[k]       = wrapped_byte(matched_reg, pat_len_reg[k], pat_rdata[8*k +: 8]);
            eq[k]       = mask_reg[k] && (wb[k] == byte_reg);
            done[k]     = eq[k] && (32'(matched_reg) + 1 == 32'(pat_len_reg[k]) + 4);
        end
    end

    // Lowest completing key wins; prefix is spelled from the lowest candidate
    always_comb
    begin
        full_any  = 1'b0;
        full_key  = '0;
        first_key = '0;
        for (int k = MAX_KEYS - 1; k >= 0; k--)
        begin
            if (done[k])
            begin
                full_any = 1'b1;
                full_key = KW'(k);
            end
            if (mask_reg[k])
            begin
                first_key = KW'(k);
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        active_next  = active_reg;
        matched_next = matched_reg;
        mask_next    = mask_reg;
        pat_len_next = pat_len_reg;
        val_len_next = val_len_reg;
        byte_next    = byte_reg;
        entry_next   = entry_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        key_next     = key_reg;
        cnt_next     = cnt_reg;
        plen_next    = plen_reg;
        tail_next    = tail_reg;
        vcnt_next    = vcnt_reg;
        vlen_next    = vlen_reg;
        brace_next   = brace_reg;

        emit         = '0;
        pat_re       = 1'b0;
        pat_raddr    = '0;
        pat_we       = 1'b0;
        pat_waddr    = pos_reg;
        pat_wdata    = pat_rdata;
        val_re       = 1'b0;
        val_raddr    = '0;
        val_we       = 1'b0;
        val_waddr    = '0;
        val_wdata    = item.data_byte;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    byte_next  = item.data_byte;
                    entry_next = KW'(item.entry_index);
                    pos_next   = PAW'(item.char_index);
                    last_next  = item.final_char;
                    case (item.action)
                        ACT_STREAM:
                        begin
                            if (matched_reg == '0)
                            begin
                                if (item.data_byte == OPEN_BRACE && all_mask != '0)
                                begin
                                    matched_next = MW'(1);
                                    mask_next    = all_mask;
                                end
                                else
                                begin
                                    state_next = ST_PASS;
                                end
                            end
                            else
                            begin
                                pat_re     = 1'b1;
                                pat_raddr  = row_of(matched_reg);
                                state_next = ST_MATCH;
                            end
                        end
                        ACT_END:
                        begin
                            if (matched_reg != '0)
                            begin
                                plen_next    = matched_reg;
                                key_next     = first_key;
                                tail_next    = 1'b0;
                                cnt_next     = '0;
                                matched_next = '0;
                                mask_next    = '0;
                                pat_re       = 1'b1;
                                pat_raddr    = row_of('0);
                                state_next   = ST_PWR;
                            end
                        end
                        ACT_LOAD_PAT:
                        begin
                            // read-modify-write of one lane of the row
                            if (load_ok && 32'(item.char_index) < PATTERN_BYTES)
                            begin
                                pat_re     = 1'b1;
                                pat_raddr  = PAW'(item.char_index);
                                state_next = ST_PLOAD;
                            end
                        end
                        ACT_LOAD_VAL:
                        begin
                            if (load_ok && 32'(item.char_index) < VALUE_BYTES)
                            begin
                                val_we    = 1'b1;
                                val_waddr = val_addr(KW'(item.entry_index),
                                                     VLW'(item.char_index));
                                if (item.final_char)
                                begin
                                    val_len_next[KW'(item.entry_index)] =
                                        VLW'(32'(item.char_index) + 1);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_PLOAD:
            begin
                pat_we = 1'b1;
                for (int k = 0; k < MAX_KEYS; k++)
                begin
                    if (KW'(k) == entry_reg)
                    begin
                        pat_wdata[8*k +: 8] = byte_reg;
                    end
                end
                if (last_reg)
                begin
                    pat_len_next[entry_reg] = PLW'(32'(pos_reg) + 1);
                end
                state_next = ST_IDLE;
            end

            ST_MATCH:
            begin
                if (full_any)
                begin
                    key_next     = full_key;
                    vcnt_next    = '0;
                    vlen_next    = val_len_reg[full_key];
                    matched_next = '0;
                    mask_next    = '0;
                    if (val_len_reg[full_key] != '0)
                    begin
                        val_re     = 1'b1;
                        val_raddr  = val_addr(full_key, '0);
                        state_next = ST_VWR;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (eq != '0)
                begin
                    mask_next    = eq;
                    matched_next = matched_reg + MW'(1);
                    state_next   = ST_IDLE;
                end
                else if (32'(matched_reg) == 2 && byte_reg == OPEN_BRACE)
                begin
                    // third brace: drop one, keep two matched; with no key active, emit all three
                    mask_next = all_mask;
                    if (all_mask == '0)
                    begin
                        matched_next = '0;
                        brace_next   = 2'd3;
                    end
                    else
                    begin
                        brace_next = 2'd1;
                    end
                    state_next = ST_BRACE;
                end
                else
                begin
                    plen_next = matched_reg;
                    key_next  = first_key;
                    cnt_next  = '0;
                    pat_re    = 1'b1;
                    pat_raddr = row_of('0);
                    if (byte_reg == OPEN_BRACE && all_mask != '0)
                    begin
                        matched_next = MW'(1);
                        mask_next    = all_mask;
                        tail_next    = 1'b0;
                    end
                    else
                    begin
                        matched_next = '0;
                        mask_next    = '0;
                        tail_next    = 1'b1;
                    end
                    state_next = ST_PWR;
                end
            end

            ST_PASS:
            begin
                if (slot_free)
                begin
                    emit.push  = 1'b1;
                    emit.data  = byte_reg;
                    emit.last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_BRACE:
            begin
                if (slot_free)
                begin
                    emit.push  = 1'b1;
                    emit.data  = OPEN_BRACE;
                    emit.last  = (brace_reg == 2'd1);
                    brace_next = brace_reg - 2'd1;
                    if (brace_reg == 2'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_PWR:
            begin
                // next row is fetched as the current byte leaves
                if (slot_free)
                begin
                    emit.push = 1'b1;
                    emit.data = walk_byte;
                    emit.last = (cnt_inc == plen_reg) && !tail_reg;
                    if (cnt_inc == plen_reg)
                    begin
                        state_next = tail_reg ? ST_PASS : ST_IDLE;
                    end
                    else
                    begin
                        cnt_next  = cnt_inc;
                        pat_re    = 1'b1;
                        pat_raddr = row_of(cnt_inc);
                    end
                end
            end

            ST_VWR:
            begin
                if (slot_free)
                begin
                    emit.push = 1'b1;
                    emit.data = val_rdata;
                    emit.last = (vcnt_inc == vlen_reg);
                    if (vcnt_inc == vlen_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        vcnt_next = vcnt_inc;
                        val_re    = 1'b1;
                        val_raddr = val_addr(key_reg, vcnt_inc);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            active_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            active_reg  <= '0;
            matched_reg <= '0;
            mask_reg    <= '0;
            for (int k = 0; k < MAX_KEYS; k++)
            begin
                pat_len_reg[k] <= '0;
                val_len_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            matched_reg <= matched_next;
            mask_reg    <= mask_next;
            pat_len_reg <= pat_len_next;
            val_len_reg <= val_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        entry_reg <= entry_next;
        pos_reg   <= pos_next;
        last_reg  <= last_next;
        key_reg   <= key_next;
        cnt_reg   <= cnt_next;
        plen_reg  <= plen_next;
        tail_reg  <= tail_next;
        vcnt_reg  <= vcnt_next;
        vlen_reg  <= vlen_next;
        brace_reg <= brace_next;
    end

    `SKS_ASSERT_IMPLY(a_mask_tracks_match, 1'b1,
        (matched_reg == '0) == (mask_reg == '0), "candidate mask out of step with match count")
    `SKS_ASSERT_IMPLY(a_push_into_free_slot, emit.push, slot_free,
        "byte pushed into a full output register")
    `SKS_ASSERT_IMPLY(a_match_bound, 1'b1, 32'(matched_reg) < PATTERN_BYTES + 4,
        "match count beyond longest wrapped pattern")
    `SKS_ASSERT_IMPLY(a_value_count, state_reg == ST_VWR, vcnt_reg < vlen_reg,
        "value walk past its length")
    `SKS_ASSERT_NEXT(a_pattern_rmw, pat_re && state_reg == ST_IDLE && item.action == ACT_LOAD_PAT,
        pat_we, "pattern row read without write-back")

endmodule

@@ src/stream_key_substitution.sv @@
// Top level of the streaming key substitution block.
// Depends on sks_pkg, sks_if, sks_ram, sks_out_reg and sks_core.
//
//  channel   interface          role    carries
//  item      sks_in_if.sink     in      action, data_byte, entry_index, char_index, final_char
//  result    sks_out_if.source  out     out_byte, run_end
//  cfg       cfg_we/cfg_wdata   in      active_keys, written on any edge with cfg_we high
//
// Pass-through byte: taken in ST_IDLE, then loaded into the output register from ST_PASS.
// Stream byte while matching: the pattern RAM row is read on acceptance, then compared in ST_MATCH.
// Value or prefix bytes: the next registered RAM read is issued as each byte is pushed.
// Pattern load: row read in ST_IDLE, lane written back in ST_PLOAD; value load: written on acceptance.
// Reset clears match state and all key lengths at once; no clearing pass is run.
// A stalled result sink holds the sequencer; the next item is taken while the last byte waits.
module stream_key_substitution #(
    parameter int MAX_KEYS      = sks_pkg::MAX_KEYS_DEF,
    parameter int PATTERN_BYTES = sks_pkg::PATTERN_BYTES_DEF,
    parameter int VALUE_BYTES   = sks_pkg::VALUE_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  sks_pkg::active_t cfg_wdata,
    sks_in_if.sink           item,
    sks_out_if.source        result
);
    import sks_pkg::*;

    localparam int PAW    = $clog2(PATTERN_BYTES);
    localparam int VDEPTH = MAX_KEYS * VALUE_BYTES;
    localparam int VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;

    emit_t                 emit;
    logic                  slot_free;
    logic                  pat_re;
    logic [PAW-1:0]        pat_raddr;
    logic                  pat_we;
    logic [PAW-1:0]        pat_waddr;
    logic [8*MAX_KEYS-1:0] pat_wdata;
    logic [8*MAX_KEYS-1:0] pat_rdata;
    logic                  val_re;
    logic [VAW-1:0]        val_raddr;
    logic                  val_we;
    logic [VAW-1:0]        val_waddr;
    logic [7:0]            val_wdata;
    logic [7:0]            val_rdata;

    sks_core #(
        .MAX_KEYS      (MAX_KEYS),
        .PATTERN_BYTES (PATTERN_BYTES),
        .VALUE_BYTES   (VALUE_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .slot_free (slot_free),
        .emit      (emit),
        .pat_re    (pat_re),
        .pat_raddr (pat_raddr),
        .pat_we    (pat_we),
        .pat_waddr (pat_waddr),
        .pat_wdata (pat_wdata),
        .pat_rdata (pat_rdata),
        .val_re    (val_re),
        .val_raddr (val_raddr),
        .val_we    (val_we),
        .val_waddr (val_waddr),
        .val_wdata (val_wdata),
        .val_rdata (val_rdata)
    );

    // One row per pattern position, one byte lane per key
    sks_ram #(
        .WIDTH (8 * MAX_KEYS),
        .DEPTH (PATTERN_BYTES)
    ) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_waddr),
        .wdata (pat_wdata),
        .re    (pat_re),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    sks_ram #(
        .WIDTH (8),
        .DEPTH (VDEPTH)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .re    (val_re),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    sks_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .slot_free (slot_free),
        .result    (result)
    );

endmodule
